>>> design/isort_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isort_pkg
// Shared constants and types of the insertion sorter: store depth, data and
// counter widths, the sorter states, the cell control word and the link between neighboring cells.
// ----------------------------------------------------------------------------
package isort_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int DATA_W    = 32;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_DRAIN
    } sorter_state_t;

    // Broadcast to every cell in a cycle.
    typedef struct packed {
        logic                     insert;
        logic                     shift;
        logic signed [DATA_W-1:0] din;
    } cell_ctl_t;

    // Passed from a cell to its right-hand neighbor.
    typedef struct packed {
        logic                     gt;
        logic                     occ;
        logic signed [DATA_W-1:0] value;
    } link_t;

endpackage

>>> design/isort_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isort_cell
// One slot of the sorted chain. On insert it compares the new value with its
// own, and keeps, takes the new value, or takes its left neighbor's value. On
// drain it takes its right neighbor's value.
// ----------------------------------------------------------------------------
module isort_cell (
    input  logic                                 aclk,
    input  isort_pkg::cell_ctl_t                 ctl,
    input  isort_pkg::link_t                     left_in,
    input  logic signed [isort_pkg::DATA_W-1:0]  right_value,
    input  logic                                 occ,
    output isort_pkg::link_t                     right_out,
    output logic signed [isort_pkg::DATA_W-1:0]  value_out
);
    import isort_pkg::*;

    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;
    logic                     gt;

    // Strictly greater keeps equal values in arrival order.
    assign gt = occ && (value_reg > ctl.din);

    always_comb begin
        value_next = value_reg;
        if (ctl.shift) begin
            value_next = right_value;
        end else if (ctl.insert) begin
            if (left_in.gt) begin
                value_next = left_in.value;
            end else if (gt || (!occ && left_in.occ)) begin
                value_next = ctl.din;
            end
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign right_out.gt    = gt;
    assign right_out.occ   = occ;
    assign right_out.value = value_reg;
    assign value_out       = value_reg;

endmodule

>>> design/insertion_sorter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// insertion_sorter
// Stable ascending sort of signed values in a chain of compare cells.
// A value is placed in the chain when it is accepted; after the last beat the
// run drains one beat per cycle from the first cell while the receiver is not
// stalling. Throughput: one input beat per cycle while filling, the chain
// being compared in all cells at once; input is held off for the drain.
// Reset (aresetn low, sync) returns to idle and clears the count, the overflow
// flag and the output valid flag.
// ----------------------------------------------------------------------------
module insertion_sorter (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [isort_pkg::DATA_W-1:0]        s_tdata,   // [31:0] value
    input  logic                                s_tlast,   // final_item
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [isort_pkg::DATA_W-1:0]        m_tdata,   // [31:0] sorted_value
    output logic                                m_tlast,   // run_end
    output logic [0:0]                          m_tuser    // [0] overflow
);
    import isort_pkg::*;

    sorter_state_t            state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     dropped_reg, dropped_next;
    logic                     out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]        out_data_reg, out_data_next;
    logic                     out_last_reg, out_last_next;
    logic                     out_ovf_reg, out_ovf_next;

    logic                     accept;
    logic                     full;
    logic                     load_out;
    cell_ctl_t                ctl;
    link_t                    link       [MAX_ITEMS+1];
    logic signed [DATA_W-1:0] cell_value [MAX_ITEMS+1];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == CNT_W'(MAX_ITEMS));
    assign load_out = (state_reg == ST_DRAIN) && (!out_valid_reg || m_tready);

    assign ctl.insert = accept && !full;
    assign ctl.shift  = load_out;
    assign ctl.din    = s_tdata;

    assign link[0].gt    = 1'b0;
    assign link[0].occ   = 1'b1;
    assign link[0].value = '0;
    assign cell_value[MAX_ITEMS] = '0;

    for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
        isort_cell u_cell (
            .aclk        (aclk),
            .ctl         (ctl),
            .left_in     (link[i]),
            .right_value (cell_value[i+1]),
            .occ         (CNT_W'(i) < count_reg),
            .right_out   (link[i+1]),
            .value_out   (cell_value[i])
        );
    end

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;

        if (m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (full) begin
                        dropped_next = 1'b1;
                    end else begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (s_tlast) begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                // Count doubles as the number of values still in the chain.
                if (load_out) begin
                    out_valid_next = 1'b1;
                    out_data_next  = cell_value[0];
                    out_last_next  = (count_reg == CNT_W'(1));
                    out_ovf_next   = dropped_reg;
                    count_next     = count_reg - CNT_W'(1);
                    if (count_reg == CNT_W'(1)) begin
                        dropped_next = 1'b0;
                        state_next   = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tlast    = out_last_reg;
    assign m_tuser[0] = out_ovf_reg;

endmodule

>>> dv/insertion_sorter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// insertion_sorter_test
// Self-checking bench for the insertion sorter. Runs of signed values are
// streamed in, each closed by a tlast beat. A behavioral sort predicts the
// output run, and every output beat is compared field by field with it.
// A short directed table comes first, then a long receiver hold-off with full
// and overflowing runs that fills the store and backs up the input, then
// random runs under three idle profiles.
// ----------------------------------------------------------------------------
module insertion_sorter_test;

    localparam int DATA_W     = isort_pkg::DATA_W;
    localparam int DEPTH      = isort_pkg::MAX_ITEMS;
    localparam int LONG_HOLD  = 400;
    localparam int WD_LIMIT   = 2000;
    localparam int TAIL_WAIT  = 16;
    localparam int MAX_REPORT = 10;
    localparam int DIR_ROWS   = 23;

    localparam int VAL_FULL   = 0;
    localparam int VAL_NARROW = 1;
    localparam int VAL_EDGE   = 2;

    localparam logic [DATA_W-1:0] S_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] S_MAX = 32'h7FFF_FFFF;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     run_end;
        logic                     ovf;
    } sorted_beat_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              fin;
        logic              typed;
        sorted_beat_t      want;
    } dir_row_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata  = '0;
    logic              s_tlast  = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;
    logic              m_tlast;
    logic [0:0]        m_tuser;

    // Behavioral copy of the store
    logic signed [DATA_W-1:0] held_vals [$];
    logic                     held_dropped = 1'b0;
    sorted_beat_t             sorted_exp_q [$];

    int   snd_idle     = 32;
    int   rcv_idle     = 59;
    int   items_sent   = 0;
    int   mismatch_cnt = 0;
    int   quiet_cycles = 0;
    logic hold_tgl     = 1'b0;
    logic hold_ack     = 1'b0;
    sorted_beat_t got_beat;
    sorted_beat_t want_beat;

    // Single-value runs carry their result inline; the rest go to the predictor.
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{S_MIN,        1'b1, 1'b1, '{S_MIN,        1'b1, 1'b0}},
        '{S_MAX,        1'b1, 1'b1, '{S_MAX,        1'b1, 1'b0}},
        '{32'h0000_0000, 1'b1, 1'b1, '{32'h0000_0000, 1'b1, 1'b0}},
        '{32'hFFFF_FFFF, 1'b1, 1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b0}},
        '{32'd5,        1'b0, 1'b0, '0},
        '{-32'sd3,      1'b0, 1'b0, '0},
        '{32'd5,        1'b0, 1'b0, '0},
        '{S_MAX,        1'b0, 1'b0, '0},
        '{S_MIN,        1'b1, 1'b0, '0},
        '{32'd40,       1'b0, 1'b0, '0},
        '{32'd30,       1'b0, 1'b0, '0},
        '{32'd20,       1'b0, 1'b0, '0},
        '{32'd10,       1'b1, 1'b0, '0},
        '{32'd1,        1'b0, 1'b0, '0},
        '{32'd2,        1'b0, 1'b0, '0},
        '{32'd3,        1'b0, 1'b0, '0},
        '{32'd4,        1'b1, 1'b0, '0},
        '{-32'sd7,      1'b0, 1'b0, '0},
        '{-32'sd7,      1'b0, 1'b0, '0},
        '{-32'sd7,      1'b1, 1'b0, '0},
        '{S_MIN,        1'b0, 1'b0, '0},
        '{S_MIN,        1'b1, 1'b0, '0},
        '{32'd1,        1'b1, 1'b1, '{32'd1,        1'b1, 1'b0}}
    };

    insertion_sorter u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Stable insert behind equal values; a full store drops and flags.
    function automatic void insert_and_emit(input logic signed [DATA_W-1:0] v,
                                            input logic fin, input logic publish);
        int pos;
        sorted_beat_t b;
        if (held_vals.size() >= DEPTH) begin
            held_dropped = 1'b1;
        end else begin
            pos = held_vals.size();
            while (pos > 0 && held_vals[pos-1] > v) pos--;
            held_vals.insert(pos, v);
        end
        if (fin) begin
            for (int k = 0; k < held_vals.size(); k++) begin
                b.value   = held_vals[k];
                b.run_end = (k == held_vals.size() - 1);
                b.ovf     = held_dropped;
                if (publish) sorted_exp_q.push_back(b);
            end
            held_vals.delete();
            held_dropped = 1'b0;
        end
    endfunction

    function automatic logic [DATA_W-1:0] pick_value(input int mode);
        logic [DATA_W-1:0] v;
        case (mode)
            VAL_NARROW: begin
                v = DATA_W'($urandom_range(0, 15)) - 32'd8;
            end
            VAL_EDGE: begin
                case ($urandom_range(0, 3))
                    0: v = S_MIN;
                    1: v = S_MAX;
                    2: v = '0;
                    default: v = $urandom;
                endcase
            end
            default: begin
                v = $urandom;
            end
        endcase
        return v;
    endfunction

    task automatic send_beat(input logic [DATA_W-1:0] v, input logic fin,
                             input logic typed, input sorted_beat_t want);
        while ($urandom_range(0, 99) < snd_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= fin;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (typed) begin
            insert_and_emit(v, fin, 1'b0);
            sorted_exp_q.push_back(want);
        end else begin
            insert_and_emit(v, fin, 1'b1);
        end
    endtask

    task automatic send_run(input int len, input int mode);
        for (int i = 0; i < len; i++) begin
            send_beat(pick_value(mode), i == len - 1, 1'b0, '0);
        end
    endtask

    task automatic random_runs(input int upto);
        int r;
        int len;
        while (items_sent < upto) begin
            r = $urandom_range(0, 99);
            if (r < 70) len = $urandom_range(1, 12);
            else if (r < 92) len = $urandom_range(13, 63);
            else len = $urandom_range(DEPTH, DEPTH + 8);
            send_run(len, $urandom_range(VAL_FULL, VAL_EDGE));
        end
    endtask

    // Drop valid and hold until every predicted beat is out.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sorted_exp_q.size() != 0) @(posedge aclk);
    endtask

    // Receiver: random backpressure, or a long hold-off when requested.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_tgl != hold_ack) begin
                hold_ack = hold_tgl;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            m_tready <= ($urandom_range(0, 99) >= rcv_idle);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_beat = '{m_tdata, m_tlast, m_tuser[0]};
            if (sorted_exp_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORT)
                    $display("unexpected beat: value %0d last %0b ovf %0b",
                             got_beat.value, got_beat.run_end, got_beat.ovf);
            end else begin
                want_beat = sorted_exp_q.pop_front();
                if (got_beat.value !== want_beat.value ||
                    got_beat.run_end !== want_beat.run_end ||
                    got_beat.ovf !== want_beat.ovf) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORT)
                        $display("mismatch: value %0d/%0d last %0b/%0b ovf %0b/%0b (exp/act)",
                                 want_beat.value, got_beat.value,
                                 want_beat.run_end, got_beat.run_end,
                                 want_beat.ovf, got_beat.ovf);
                end
            end
        end
    end

    // Watchdog: end the run if neither side moves a beat for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WD_LIMIT) begin
                $display("insertion_sorter_test failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            send_beat(dir_rows[i].value, dir_rows[i].fin, dir_rows[i].typed,
                      dir_rows[i].want);
        end
        wait_drained();

        // Hold the receiver: a run that drops its own tlast value, a full run
        // without overflow and a short one back up behind the drain.
        hold_tgl <= ~hold_tgl;
        send_run(DEPTH + 1, VAL_FULL);
        send_run(DEPTH, VAL_NARROW);
        send_run(3, VAL_EDGE);
        wait_drained();

        random_runs(160);
        wait_drained();
        snd_idle = 59;
        rcv_idle = 32;
        random_runs(320);
        wait_drained();
        snd_idle = 0;
        rcv_idle = 0;
        random_runs(480);
        wait_drained();

        repeat (TAIL_WAIT) @(posedge aclk);
        if (mismatch_cnt == 0 && sorted_exp_q.size() == 0) begin
            $display("insertion_sorter_test passed");
        end else begin
            $display("insertion_sorter_test failed");
        end
        $finish;
    end

endmodule
